>>> hdl/cbfp_pkg.sv
`default_nettype none
package cbfp_pkg;

    localparam int unsigned MAX_FRAME_BLOCKS_DEF = 100;

    localparam logic [15:0] WORD_START         = 16'haa55;
    localparam logic [15:0] WORD_START_CC      = 16'haa56;
    localparam logic [15:0] WORD_START_SWAPPED = 16'h55aa;
    localparam logic [15:0] WORD_IDLE          = 16'hffff;

    localparam int unsigned NUM_FIELDS = 6;

    typedef enum logic [1:0] {
        MODE_SEARCH    = 2'd0,
        MODE_CHECKSUM  = 2'd1,
        MODE_FIELDS    = 2'd2,
        MODE_SEPARATOR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RES_BLOCK     = 2'd0,
        RES_CSUM_ERR  = 2'd1,
        RES_FRAME_END = 2'd2,
        RES_NO_FRAME  = 2'd3
    } t_res_kind;

    typedef struct packed {
        t_res_kind   result_kind;
        logic        block_kind;
        logic [15:0] signature;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] angle;
        logic [6:0]  frame_block_count;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/camera_block_frame_parser.sv
`default_nettype none
// Channel   Handshake               Payload
// -------   ---------------------   ----------------------------------------
// in        i_in_valid/o_in_stall   i_rx_byte
// out       o_out_valid/i_out_stall o_result_kind .. o_frame_block_count
// cfg       i_cfg_wr_en             i_cfg_wr_data (max_blocks)
//
// One input byte per cycle while o_in_stall is low; a byte's result (at most
// one) goes into the output register. A one-entry skid buffer behind the output
// register keeps input flowing while the output is stalled; o_in_stall rises
// only when that buffer is full. Synchronous active-low reset, no clearing pass.
module camera_block_frame_parser #(
    parameter int unsigned MAX_FRAME_BLOCKS = cbfp_pkg::MAX_FRAME_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic             o_block_kind,
    output logic [15:0]      o_signature,
    output logic [15:0]      o_x_pos,
    output logic [15:0]      o_y_pos,
    output logic [15:0]      o_box_width,
    output logic [15:0]      o_box_height,
    output logic [15:0]      o_angle,
    output logic [6:0]       o_frame_block_count
);
    import cbfp_pkg::*;

    localparam logic [7:0] LIMIT_CAP = 8'(MAX_FRAME_BLOCKS);

    logic [6:0]  r_max_blocks;
    logic        r_phase,     n_phase;
    logic [7:0]  r_held,      n_held;
    logic        r_drop,      n_drop;
    t_mode       r_mode,      n_mode;
    logic [15:0] r_prev,      n_prev;
    logic        r_kind,      n_kind;
    logic [15:0] r_expect,    n_expect;
    logic [15:0] r_sum,       n_sum;
    logic [2:0]  r_fidx,      n_fidx;
    logic [15:0] r_store [NUM_FIELDS];
    logic [6:0]  r_count,     n_count;

    logic        r_out_valid, n_out_valid;
    t_result     r_out,       n_out;
    logic        r_skid_valid, n_skid_valid;
    t_result     r_skid,      n_skid;

    logic        in_accept;
    logic        word_en;
    logic [15:0] word;
    logic        is_start;
    logic [15:0] sum_add;
    logic        last_field;
    logic [7:0]  limit;
    logic        res_valid;
    t_result     res;
    logic [15:0] fld [NUM_FIELDS];

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign word_en    = in_accept && !r_drop && r_phase;
    assign word       = {r_held, i_rx_byte};
    assign is_start   = (word == WORD_START) || (word == WORD_START_CC);
    assign sum_add    = r_sum + word;
    assign last_field = (r_fidx == (r_kind ? 3'd5 : 3'd4));

    always_comb begin
        limit = {1'b0, r_max_blocks};
        if (limit == 8'd0) begin
            limit = 8'd1;
        end
        if (limit > LIMIT_CAP) begin
            limit = LIMIT_CAP;
        end
    end

    // current word merged into the stored block fields
    always_comb begin
        for (int j = 0; j < NUM_FIELDS; j++) begin
            fld[j] = (r_fidx == 3'(j)) ? word : r_store[j];
        end
        if (!r_kind) begin
            fld[NUM_FIELDS-1] = 16'd0;
        end
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_drop   = r_drop;
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_kind   = r_kind;
        n_expect = r_expect;
        n_sum    = r_sum;
        n_fidx   = r_fidx;
        n_count  = r_count;
        if (in_accept) begin
            if (r_drop) begin
                n_drop = 1'b0;
            end else if (!r_phase) begin
                n_held  = i_rx_byte;
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                case (r_mode)
                    MODE_SEARCH: begin
                        if (word == 16'd0 && r_prev == 16'd0) begin
                            n_prev = WORD_IDLE;
                        end else if (r_prev == WORD_START && is_start) begin
                            n_kind  = (word == WORD_START_CC);
                            n_count = '0;
                            n_mode  = MODE_CHECKSUM;
                        end else begin
                            if (word == WORD_START_SWAPPED) begin
                                n_drop = 1'b1;
                            end
                            n_prev = word;
                        end
                    end
                    MODE_CHECKSUM: begin
                        if (is_start) begin
                            n_kind  = (word == WORD_START_CC);
                            n_count = '0;
                        end else if (word == 16'd0) begin
                            n_mode = MODE_SEARCH;
                            n_prev = WORD_IDLE;
                        end else begin
                            n_expect = word;
                            n_sum    = '0;
                            n_fidx   = '0;
                            n_mode   = MODE_FIELDS;
                        end
                    end
                    MODE_FIELDS: begin
                        n_sum  = sum_add;
                        n_fidx = r_fidx + 3'd1;
                        if (last_field) begin
                            if (sum_add == r_expect) begin
                                n_count = r_count + 7'd1;
                            end
                            n_mode = MODE_SEPARATOR;
                        end
                    end
                    MODE_SEPARATOR: begin
                        if (is_start) begin
                            n_kind = (word == WORD_START_CC);
                            if ({1'b0, r_count} >= limit) begin
                                n_mode = MODE_SEARCH;
                                n_prev = WORD_IDLE;
                            end else begin
                                n_mode = MODE_CHECKSUM;
                            end
                        end else begin
                            n_mode = MODE_SEARCH;
                            n_prev = WORD_IDLE;
                        end
                    end
                    default: begin
                        n_mode = MODE_SEARCH;
                    end
                endcase
            end
        end
    end

    // result generation
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        res.frame_block_count = r_count;
        if (word_en) begin
            case (r_mode)
                MODE_SEARCH: begin
                    if (word == 16'd0 && r_prev == 16'd0) begin
                        res_valid             = 1'b1;
                        res.result_kind       = RES_NO_FRAME;
                        res.frame_block_count = '0;
                    end
                end
                MODE_CHECKSUM: begin
                    if (is_start || word == 16'd0) begin
                        res_valid       = 1'b1;
                        res.result_kind = RES_FRAME_END;
                    end
                end
                MODE_FIELDS: begin
                    if (last_field) begin
                        res_valid       = 1'b1;
                        res.block_kind  = r_kind;
                        res.signature   = fld[0];
                        res.x_pos       = fld[1];
                        res.y_pos       = fld[2];
                        res.box_width   = fld[3];
                        res.box_height  = fld[4];
                        res.angle       = fld[5];
                        if (sum_add == r_expect) begin
                            res.result_kind       = RES_BLOCK;
                            res.frame_block_count = r_count + 7'd1;
                        end else begin
                            res.result_kind = RES_CSUM_ERR;
                        end
                    end
                end
                MODE_SEPARATOR: begin
                    if (!is_start || {1'b0, r_count} >= limit) begin
                        res_valid       = 1'b1;
                        res.result_kind = RES_FRAME_END;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // output register with skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = res_valid;
            end
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blocks <= 7'd1;
            r_phase      <= 1'b0;
            r_held       <= '0;
            r_drop       <= 1'b0;
            r_mode       <= MODE_SEARCH;
            r_prev       <= WORD_IDLE;
            r_kind       <= 1'b0;
            r_expect     <= '0;
            r_sum        <= '0;
            r_fidx       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_blocks <= i_cfg_wr_data;
            end
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_drop       <= n_drop;
            r_mode       <= n_mode;
            r_prev       <= n_prev;
            r_kind       <= n_kind;
            r_expect     <= n_expect;
            r_sum        <= n_sum;
            r_fidx       <= n_fidx;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (word_en && r_mode == MODE_FIELDS) begin
            r_store[r_fidx] <= word;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out.result_kind;
    assign o_block_kind        = r_out.block_kind;
    assign o_signature         = r_out.signature;
    assign o_x_pos             = r_out.x_pos;
    assign o_y_pos             = r_out.y_pos;
    assign o_box_width         = r_out.box_width;
    assign o_box_height        = r_out.box_height;
    assign o_angle             = r_out.angle;
    assign o_frame_block_count = r_out.frame_block_count;

endmodule
`default_nettype wire

>>> tb/tb_camera_block_frame_parser.sv
`default_nettype none
import cbfp_pkg::*;

function automatic bit is_start_word(logic [15:0] w);
    return (w == WORD_START) || (w == WORD_START_CC);
endfunction

// Tracks the parser byte by byte and keeps the reports it should produce.
class report_scoreboard;
    t_result     awaited[$];
    int          errors;
    logic [6:0]  max_blocks;
    logic        byte_phase;
    logic [7:0]  held_high;
    logic        drop_next;
    t_mode       parse_state;
    logic [15:0] prev_word;
    logic        cur_cc;
    logic [15:0] want_sum;
    logic [15:0] run_sum;
    int unsigned field_idx;
    logic [15:0] fields [NUM_FIELDS];
    logic [6:0]  valid_cnt;

    function new();
        errors      = 0;
        max_blocks  = 7'd1;
        byte_phase  = 1'b0;
        held_high   = '0;
        drop_next   = 1'b0;
        parse_state = MODE_SEARCH;
        prev_word   = WORD_IDLE;
        cur_cc      = 1'b0;
        want_sum    = '0;
        run_sum     = '0;
        field_idx   = 0;
        foreach (fields[i]) fields[i] = '0;
        valid_cnt   = '0;
    endfunction

    function void set_limit(logic [6:0] v);
        max_blocks = v;
    endfunction

    function int unsigned frame_limit();
        if (max_blocks == 7'd0) return 1;
        if (32'(max_blocks) > MAX_FRAME_BLOCKS_DEF) return MAX_FRAME_BLOCKS_DEF;
        return 32'(max_blocks);
    endfunction

    function void go_search();
        parse_state = MODE_SEARCH;
        prev_word   = WORD_IDLE;
    endfunction

    function void push_event(t_res_kind k, logic [6:0] cnt);
        t_result r;
        r = '0;
        r.result_kind       = k;
        r.frame_block_count = cnt;
        awaited.push_back(r);
    endfunction

    function void parse_word(logic [15:0] w);
        t_result    r;
        logic [6:0] cnt;
        case (parse_state)
            MODE_SEARCH: begin
                if (w == 16'h0000 && prev_word == 16'h0000) begin
                    go_search();
                    push_event(RES_NO_FRAME, 7'd0);
                end else if (prev_word == WORD_START && is_start_word(w)) begin
                    cur_cc      = (w == WORD_START_CC);
                    valid_cnt   = '0;
                    parse_state = MODE_CHECKSUM;
                end else begin
                    // byte-swapped start: stream is one byte off
                    if (w == WORD_START_SWAPPED) drop_next = 1'b1;
                    prev_word = w;
                end
            end
            MODE_CHECKSUM: begin
                if (is_start_word(w)) begin
                    // new frame starts right away, no second start word
                    cnt       = valid_cnt;
                    cur_cc    = (w == WORD_START_CC);
                    valid_cnt = '0;
                    push_event(RES_FRAME_END, cnt);
                end else if (w == 16'h0000) begin
                    go_search();
                    push_event(RES_FRAME_END, valid_cnt);
                end else begin
                    want_sum    = w;
                    run_sum     = '0;
                    field_idx   = 0;
                    parse_state = MODE_FIELDS;
                end
            end
            MODE_FIELDS: begin
                fields[3'(field_idx % NUM_FIELDS)] = w;
                run_sum = run_sum + w;
                field_idx++;
                if (field_idx >= (cur_cc ? 6 : 5)) begin
                    if (!cur_cc) fields[5] = '0;
                    r = '0;
                    if (run_sum == want_sum) begin
                        valid_cnt     = valid_cnt + 7'd1;
                        r.result_kind = RES_BLOCK;
                    end else begin
                        r.result_kind = RES_CSUM_ERR;
                    end
                    r.block_kind        = cur_cc;
                    r.signature         = fields[0];
                    r.x_pos             = fields[1];
                    r.y_pos             = fields[2];
                    r.box_width         = fields[3];
                    r.box_height        = fields[4];
                    r.angle             = fields[5];
                    r.frame_block_count = valid_cnt;
                    awaited.push_back(r);
                    parse_state = MODE_SEPARATOR;
                end
            end
            default: begin
                if (is_start_word(w)) begin
                    cur_cc = (w == WORD_START_CC);
                    if (32'(valid_cnt) >= frame_limit()) begin
                        go_search();
                        push_event(RES_FRAME_END, valid_cnt);
                    end else begin
                        parse_state = MODE_CHECKSUM;
                    end
                end else begin
                    go_search();
                    push_event(RES_FRAME_END, valid_cnt);
                end
            end
        endcase
    endfunction

    function void note_byte(logic [7:0] b);
        if (drop_next) begin
            drop_next = 1'b0;
            return;
        end
        if (!byte_phase) begin
            held_high  = b;
            byte_phase = 1'b1;
            return;
        end
        byte_phase = 1'b0;
        parse_word({held_high, b});
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_report(t_result got);
        t_result want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, kind %0d count %0d",
                     $time, got.result_kind, got.frame_block_count);
            errors++;
            return;
        end
        want = awaited.pop_front();
        compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        compare_field("block_kind", 16'(want.block_kind), 16'(got.block_kind));
        compare_field("signature", want.signature, got.signature);
        compare_field("x_pos", want.x_pos, got.x_pos);
        compare_field("y_pos", want.y_pos, got.y_pos);
        compare_field("box_width", want.box_width, got.box_width);
        compare_field("box_height", want.box_height, got.box_height);
        compare_field("angle", want.angle, got.angle);
        compare_field("frame_block_count", 16'(want.frame_block_count),
                      16'(got.frame_block_count));
    endfunction
endclass

module tb_camera_block_frame_parser;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [6:0]  i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic        o_block_kind;
    logic [15:0] o_signature;
    logic [15:0] o_x_pos;
    logic [15:0] o_y_pos;
    logic [15:0] o_box_width;
    logic [15:0] o_box_height;
    logic [15:0] o_angle;
    logic [6:0]  o_frame_block_count;

    report_scoreboard sb = new();

    int          bytes_sent = 0;
    bit          quiet = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned cur_limit = 1;
    int          out_wait_left = 0;

    always #1 i_clk = ~i_clk;

    camera_block_frame_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_kind       (o_result_kind),
        .o_block_kind        (o_block_kind),
        .o_signature         (o_signature),
        .o_x_pos             (o_x_pos),
        .o_y_pos             (o_y_pos),
        .o_box_width         (o_box_width),
        .o_box_height        (o_box_height),
        .o_angle             (o_angle),
        .o_frame_block_count (o_frame_block_count)
    );

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side: check accepted words, then choose next stall
    always @(posedge i_clk) begin : result_side
        t_result got;
        if (!i_rst_n) begin
            i_out_stall   <= 1'b0;
            out_wait_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got                   = '0;
                got.result_kind       = t_res_kind'(o_result_kind);
                got.block_kind        = o_block_kind;
                got.signature         = o_signature;
                got.x_pos             = o_x_pos;
                got.y_pos             = o_y_pos;
                got.box_width         = o_box_width;
                got.box_height        = o_box_height;
                got.angle             = o_angle;
                got.frame_block_count = o_frame_block_count;
                sb.check_report(got);
            end
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else if (out_wait_left > 0) begin
                out_wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                out_wait_left = pick_gap();
                if (out_wait_left > 0) begin
                    out_wait_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the skid buffer fills and input stalls
    initial begin : long_hold
        wait (bytes_sent >= 260);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic push_word(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    function automatic logic [15:0] any_field();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] plain_word();
        logic [15:0] w;
        do w = 16'($urandom); while (is_start_word(w));
        return w;
    endfunction

    function automatic logic [15:0] start_of(bit cc);
        return cc ? WORD_START_CC : WORD_START;
    endfunction

    // checksum word then 5 or 6 fields; sum kept clear of the special words
    task automatic push_block(input bit cc, input bit good);
        logic [15:0] f [6];
        logic [15:0] sum;
        logic [15:0] csum;
        int          n;
        n = cc ? 6 : 5;
        do begin
            sum = '0;
            for (int i = 0; i < n; i++) begin
                f[i] = any_field();
                sum  = sum + f[i];
            end
        end while (sum == 16'h0000 || is_start_word(sum));
        csum = sum;
        if (!good) begin
            do csum = 16'($urandom);
            while (csum == sum || csum == 16'h0000 || is_start_word(csum));
        end
        push_word(csum);
        for (int i = 0; i < n; i++) push_word(f[i]);
    endtask

    task automatic finish_frame();
        bit cc;
        case ($urandom_range(0, 3))
            0: push_word(plain_word());
            1: push_word(16'h0000);
            2: begin
                // separator then zero checksum
                push_word(start_of(1'($urandom_range(0, 1))));
                push_word(16'h0000);
            end
            default: begin
                // start word where a checksum belongs: next frame follows at once
                cc = 1'($urandom_range(0, 1));
                push_word(start_of(1'($urandom_range(0, 1))));
                push_word(start_of(cc));
                push_block(cc, $urandom_range(0, 3) != 0);
                push_word(plain_word());
            end
        endcase
    endtask

    task automatic push_frame(input int nb, input int pct_good);
        bit cc;
        cc = 1'($urandom_range(0, 1));
        push_word(WORD_START);
        push_word(start_of(cc));
        for (int i = 0; i < nb; i++) begin
            push_block(cc, $urandom_range(0, 99) < pct_good);
            if (i < nb - 1) begin
                cc = 1'($urandom_range(0, 1));
                push_word(start_of(cc));
            end
        end
        finish_frame();
    endtask

    task automatic push_noise();
        int k;
        case ($urandom_range(0, 3))
            0: begin
                k = $urandom_range(1, 7);
                repeat (k) send_byte(8'($urandom));
            end
            1: begin
                push_word(WORD_START_SWAPPED);
                send_byte(8'($urandom));
            end
            2: begin
                push_word(16'h0000);
                push_word(16'h0000);
            end
            default: begin
                push_word(WORD_START);
                push_word(16'($urandom));
            end
        endcase
    endtask

    // frame cut short inside a block
    task automatic push_broken();
        int k;
        push_word(WORD_START);
        push_word(start_of(1'($urandom_range(0, 1))));
        push_word(plain_word() | 16'h0001);
        k = $urandom_range(0, 4);
        repeat (k) push_word(any_field());
    endtask

    task automatic random_chunk();
        int r;
        int cap;
        r   = $urandom_range(0, 99);
        cap = (cur_limit + 1 < 6) ? cur_limit + 1 : 6;
        if (r < 70)
            push_frame($urandom_range(1, cap), 90);
        else if (r < 85)
            push_noise();
        else
            push_broken();
    endtask

    // drop valid, then wait for all reports and a margin
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [6:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_limit(v);
        if (v == 7'd0)
            cur_limit = 1;
        else if (32'(v) > MAX_FRAME_BLOCKS_DEF)
            cur_limit = MAX_FRAME_BLOCKS_DEF;
        else
            cur_limit = 32'(v);
    endtask

    initial begin : stimulus
        logic [7:0] directed [21];
        logic [6:0] limits [7];
        int         phase_end;
        // no frame, swapped start with dropped byte, zero checksum,
        // start in place of checksum, then zero checksum
        directed = '{8'h00, 8'h00, 8'h00, 8'h00,
                     8'h55, 8'haa, 8'hff,
                     8'haa, 8'h55, 8'haa, 8'h55, 8'h00, 8'h00,
                     8'haa, 8'h55, 8'haa, 8'h56, 8'haa, 8'h55,
                     8'h00, 8'h00};
        limits = '{7'd1, 7'd100, 7'd127, 7'd0, 7'd2, 7'd3, 7'd5};
        limits[6] = 7'($urandom_range(2, 8));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_byte(directed[i]);
        for (int ph = 0; ph < 7; ph++) begin
            settle();
            write_limit(limits[ph]);
            quiet = (ph == 2) || ($urandom_range(0, 4) == 0);
            phase_end = bytes_sent + 150;
            while (bytes_sent < phase_end) random_chunk();
        end
        quiet = 1'b0;
        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
hdl/cbfp_pkg.sv
hdl/camera_block_frame_parser.sv
tb/tb_camera_block_frame_parser.sv
